[hw/rtl/md5_pkg.sv]
package md5_pkg;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       byte_valid;
		logic       end_of_message;
	} md5_req_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ROUND,
		ST_PAD,
		ST_LEN,
		ST_OUT0,
		ST_OUT1
	} md5_state_t;

	localparam logic [31:0] IV_A = 32'h67452301;
	localparam logic [31:0] IV_B = 32'hefcdab89;
	localparam logic [31:0] IV_C = 32'h98badcfe;
	localparam logic [31:0] IV_D = 32'h10325476;
	localparam logic [7:0]  PAD_BYTE = 8'h80;
	localparam int unsigned FIFO_DEPTH = 2;

	function automatic logic [31:0] round_k(input logic [5:0] i);
		logic [31:0] k;
		case (i)
			6'd0: k = 32'hd76aa478; 6'd1: k = 32'he8c7b756; 6'd2: k = 32'h242070db;
			6'd3: k = 32'hc1bdceee; 6'd4: k = 32'hf57c0faf; 6'd5: k = 32'h4787c62a;
			6'd6: k = 32'ha8304613; 6'd7: k = 32'hfd469501; 6'd8: k = 32'h698098d8;
			6'd9: k = 32'h8b44f7af; 6'd10: k = 32'hffff5bb1; 6'd11: k = 32'h895cd7be;
			6'd12: k = 32'h6b901122; 6'd13: k = 32'hfd987193; 6'd14: k = 32'ha679438e;
			6'd15: k = 32'h49b40821; 6'd16: k = 32'hf61e2562; 6'd17: k = 32'hc040b340;
			6'd18: k = 32'h265e5a51; 6'd19: k = 32'he9b6c7aa; 6'd20: k = 32'hd62f105d;
			6'd21: k = 32'h02441453; 6'd22: k = 32'hd8a1e681; 6'd23: k = 32'he7d3fbc8;
			6'd24: k = 32'h21e1cde6; 6'd25: k = 32'hc33707d6; 6'd26: k = 32'hf4d50d87;
			6'd27: k = 32'h455a14ed; 6'd28: k = 32'ha9e3e905; 6'd29: k = 32'hfcefa3f8;
			6'd30: k = 32'h676f02d9; 6'd31: k = 32'h8d2a4c8a; 6'd32: k = 32'hfffa3942;
			6'd33: k = 32'h8771f681; 6'd34: k = 32'h6d9d6122; 6'd35: k = 32'hfde5380c;
			6'd36: k = 32'ha4beea44; 6'd37: k = 32'h4bdecfa9; 6'd38: k = 32'hf6bb4b60;
			6'd39: k = 32'hbebfbc70; 6'd40: k = 32'h289b7ec6; 6'd41: k = 32'heaa127fa;
			6'd42: k = 32'hd4ef3085; 6'd43: k = 32'h04881d05; 6'd44: k = 32'hd9d4d039;
			6'd45: k = 32'he6db99e5; 6'd46: k = 32'h1fa27cf8; 6'd47: k = 32'hc4ac5665;
			6'd48: k = 32'hf4292244; 6'd49: k = 32'h432aff97; 6'd50: k = 32'hab9423a7;
			6'd51: k = 32'hfc93a039; 6'd52: k = 32'h655b59c3; 6'd53: k = 32'h8f0ccc92;
			6'd54: k = 32'hffeff47d; 6'd55: k = 32'h85845dd1; 6'd56: k = 32'h6fa87e4f;
			6'd57: k = 32'hfe2ce6e0; 6'd58: k = 32'ha3014314; 6'd59: k = 32'h4e0811a1;
			6'd60: k = 32'hf7537e82; 6'd61: k = 32'hbd3af235; 6'd62: k = 32'h2ad7d2bb;
			default: k = 32'heb86d391;
		endcase
		return k;
	endfunction

	function automatic logic [4:0] rot_amount(input logic [5:0] i);
		logic [4:0] s;
		case ({i[5:4], i[1:0]})
			4'd0: s = 5'd7;   4'd1: s = 5'd12;  4'd2: s = 5'd17;  4'd3: s = 5'd22;
			4'd4: s = 5'd5;   4'd5: s = 5'd9;   4'd6: s = 5'd14;  4'd7: s = 5'd20;
			4'd8: s = 5'd4;   4'd9: s = 5'd11;  4'd10: s = 5'd16; 4'd11: s = 5'd23;
			4'd12: s = 5'd6;  4'd13: s = 5'd10; 4'd14: s = 5'd15; default: s = 5'd21;
		endcase
		return s;
	endfunction

	function automatic logic [3:0] msg_index(input logic [5:0] i);
		logic [3:0] g;
		case (i[5:4])
			2'd0: g = i[3:0];
			2'd1: g = 4'(5 * i[3:0] + 1);
			2'd2: g = 4'(3 * i[3:0] + 5);
			default: g = 4'(7 * i[3:0]);
		endcase
		return g;
	endfunction

endpackage

[hw/rtl/md5_fifo.sv]
module md5_fifo (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  md5_pkg::md5_req_t push_data,
	output logic              full,
	input  logic              pop,
	output md5_pkg::md5_req_t pop_data,
	output logic              empty
);
	import md5_pkg::*;

	md5_req_t mem_q [FIFO_DEPTH];
	logic wr_q, rd_q;
	logic [1:0] cnt_q;

	assign full = cnt_q == 2'(FIFO_DEPTH);
	assign empty = cnt_q == 2'd0;
	assign pop_data = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push && !full) mem_q[wr_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= 1'b0;
			rd_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push && !full) wr_q <= !wr_q;
			if (pop && !empty) rd_q <= !rd_q;
			cnt_q <= cnt_q + 2'(push && !full) - 2'(pop && !empty);
		end
	end

`ifndef SYNTH
	a_no_over: assert property (@(posedge clk) disable iff (!arst_n) cnt_q <= 2'(FIFO_DEPTH))
		else $error("fifo count overflow");
	a_pop_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && !empty && !push) |=> cnt_q == $past(cnt_q) - 2'd1)
		else $error("fifo pop count");
	a_push_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !full && !(pop && !empty)) |=> cnt_q == $past(cnt_q) + 2'd1)
		else $error("fifo push count");
`endif

endmodule

[hw/rtl/md5_core.sv]
module md5_core (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	input  md5_pkg::md5_req_t req,
	output logic              req_ready,
	output logic              m_axis_tvalid,
	input  logic              m_axis_tready,
	output logic [63:0]       m_axis_tdata,
	output logic              m_axis_tuser,
	output logic              m_axis_tlast
);
	import md5_pkg::*;

	md5_state_t state_q, state_d;
	logic [31:0] cv_q [4];
	logic [31:0] blk_q [16];
	logic [63:0] cnt_q;
	logic [31:0] a_q, b_q, c_q, d_q;
	logic [5:0] rnd_q;
	logic [5:0] pos_q;       // next pad position within block
	logic after_q;           // what follows the running compress
	logic fin_q;             // message end pending
	logic spill_q;           // pad reached 56+, a zero block with the length follows

	// round datapath
	logic [31:0] f, sum, rot;
	logic [4:0] sh;
	always_comb begin
		case (rnd_q[5:4])
			2'd0: f = (b_q & c_q) | (~b_q & d_q);
			2'd1: f = (b_q & d_q) | (c_q & ~d_q);
			2'd2: f = b_q ^ c_q ^ d_q;
			default: f = c_q ^ (b_q | ~d_q);
		endcase
		sum = a_q + f + round_k(rnd_q) + blk_q[msg_index(rnd_q)];
		sh = rot_amount(rnd_q);
		rot = (sum << sh) | (sum >> (6'd32 - {1'b0, sh}));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else state_q <= state_d;
	end

	logic full_blk;
	assign full_blk = req.byte_valid && (cnt_q[5:0] == 6'd63);

	always_comb begin
		state_d = state_q;
		req_ready = 1'b0;
		m_axis_tvalid = 1'b0;
		m_axis_tuser = 1'b0;
		m_axis_tlast = 1'b0;
		m_axis_tdata = {cv_q[1], cv_q[0]};
		case (state_q)
			ST_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					if (full_blk) state_d = ST_ROUND;
					else if (req.end_of_message) state_d = ST_PAD;
				end
			end
			ST_ROUND: begin
				if (rnd_q == 6'd63) begin
					if (!fin_q) state_d = ST_IDLE;
					else if (spill_q) state_d = ST_LEN;
					else if (after_q) state_d = ST_OUT0;
					else state_d = ST_PAD;
				end
			end
			ST_PAD: if (pos_q == 6'd63) state_d = ST_LEN;
			ST_LEN: state_d = ST_ROUND;
			ST_OUT0: begin
				m_axis_tvalid = 1'b1;
				if (m_axis_tready) state_d = ST_OUT1;
			end
			ST_OUT1: begin
				m_axis_tvalid = 1'b1;
				m_axis_tuser = 1'b1;
				m_axis_tlast = 1'b1;
				m_axis_tdata = {cv_q[3], cv_q[2]};
				if (m_axis_tready) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// ST_PAD writes one byte per cycle from pos_q; ST_LEN decides length block
	logic pad_first_q;
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: if (req_valid && req.byte_valid)
				blk_q[cnt_q[5:2]][cnt_q[1:0]*8 +: 8] <= req.data_byte;
			// second block of a spill: zeros with length, loaded when spill compress ends
			ST_ROUND: if (rnd_q == 6'd63 && fin_q && spill_q) begin
				for (int w = 0; w < 14; w++) blk_q[w] <= '0;
				blk_q[14] <= {cnt_q[28:0], 3'b000};
				blk_q[15] <= cnt_q[60:29];
			end
			ST_PAD: blk_q[pos_q[5:2]][pos_q[1:0]*8 +: 8] <= pad_first_q ? PAD_BYTE : 8'h00;
			ST_LEN: if (!after_q) begin
				blk_q[14] <= {cnt_q[28:0], 3'b000};
				blk_q[15] <= cnt_q[60:29];
			end
			default: ;
		endcase
	end

	logic start;
	assign start = (state_q == ST_IDLE && req_valid && full_blk) || state_q == ST_LEN;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cv_q[0] <= IV_A; cv_q[1] <= IV_B; cv_q[2] <= IV_C; cv_q[3] <= IV_D;
			cnt_q <= '0;
			rnd_q <= '0;
			pos_q <= '0;
			after_q <= 1'b0;
			fin_q <= 1'b0;
			pad_first_q <= 1'b0;
			a_q <= '0; b_q <= '0; c_q <= '0; d_q <= '0;
		end else begin
			if (start) begin
				a_q <= cv_q[0]; b_q <= cv_q[1]; c_q <= cv_q[2]; d_q <= cv_q[3];
				rnd_q <= '0;
			end
			case (state_q)
				ST_IDLE: if (req_valid) begin
					if (req.byte_valid) cnt_q <= cnt_q + 64'd1;
					fin_q <= req.end_of_message;
					after_q <= 1'b0;
					pad_first_q <= 1'b1;
					pos_q <= req.byte_valid ? cnt_q[5:0] + 6'd1 : cnt_q[5:0];
				end
				ST_ROUND: begin
					{a_q, b_q, c_q, d_q} <= {d_q, b_q + rot, b_q, c_q};
					rnd_q <= rnd_q + 6'd1;
					if (rnd_q == 6'd63) begin
						cv_q[0] <= cv_q[0] + d_q;
						cv_q[1] <= cv_q[1] + b_q + rot;
						cv_q[2] <= cv_q[2] + b_q;
						cv_q[3] <= cv_q[3] + c_q;
						// full-block compress that ends a message starts padding at 0
						if (fin_q && !after_q) pos_q <= 6'd0;
					end
				end
				ST_PAD: begin
					pad_first_q <= 1'b0;
					pos_q <= pos_q + 6'd1;
					// length fits only if padding began below 56
					if (pad_first_q) after_q <= pos_q >= 6'd56;
				end
				ST_LEN: ;
				ST_OUT1: if (m_axis_tready) begin
					cv_q[0] <= IV_A; cv_q[1] <= IV_B; cv_q[2] <= IV_C; cv_q[3] <= IV_D;
					cnt_q <= '0;
					fin_q <= 1'b0;
				end
				default: ;
			endcase
			// after_q toggles: a spill block compress is followed by a length-only block
			if (state_q == ST_LEN) after_q <= 1'b1;
			if (state_q == ST_ROUND && rnd_q == 6'd63 && fin_q && after_q && spill_q) begin
				after_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) spill_q <= 1'b0;
		else if (state_q == ST_PAD && pad_first_q) spill_q <= pos_q >= 6'd56;
		else if (state_q == ST_ROUND && rnd_q == 6'd63 && spill_q) spill_q <= 1'b0;
	end

`ifndef SYNTH
	a_out_after: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_OUT1 && m_axis_tready) |=> cnt_q == 64'd0)
		else $error("count not cleared after digest");
	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		req_ready |-> !m_axis_tvalid)
		else $error("accept during output");
	a_round_step: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ROUND && rnd_q != 6'd63) |=> state_q == ST_ROUND)
		else $error("round sequence broken");
`endif

endmodule

[hw/rtl/md5_message_digest.sv]
// MD5 digest of a byte stream.
// s_axis: one request per byte; tdata[7:0] is the byte, tdata[8] marks it valid,
// tlast ends the message (an empty end marker has tdata[8] low).
// Requests enter a two-entry queue; the hashing engine drains it one at a time.
// A byte is taken while the engine idles; the 64th byte of a block also runs
// the 64 rounds of the single shared round unit.
// At end of message the engine writes pad bytes one per cycle (up to 64),
// then compresses one or two more blocks.
// m_axis: two digest words, tuser = word index, tlast on the second.
// Each word holds until taken; a stalled receiver stalls the engine, and the
// queue then fills and drops s_axis_tready.
// After the second word the chaining words return to the initial vector
// and the byte count to zero. Reset (arst_n low) does the same and empties
// the queue.
module md5_message_digest (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [15:0] s_axis_tdata,  // data_byte[7:0], byte_valid[8], zero pad
	input  logic        s_axis_tlast,  // end_of_message
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [63:0] m_axis_tdata,  // digest_word[63:0]
	output logic        m_axis_tuser,  // word_index
	output logic        m_axis_tlast   // last_word
);
	import md5_pkg::*;

	md5_req_t in_req, q_req;
	logic full, empty, pop;

	assign in_req = '{data_byte: s_axis_tdata[7:0], byte_valid: s_axis_tdata[8],
		end_of_message: s_axis_tlast};
	assign s_axis_tready = !full;

	md5_fifo u_fifo (
		.clk(clk), .arst_n(arst_n),
		.push(s_axis_tvalid), .push_data(in_req), .full(full),
		.pop(pop), .pop_data(q_req), .empty(empty)
	);

	logic core_ready;
	assign pop = core_ready && !empty;

	md5_core u_core (
		.clk(clk), .arst_n(arst_n),
		.req_valid(!empty), .req(q_req), .req_ready(core_ready),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
		.m_axis_tlast(m_axis_tlast)
	);

endmodule
